[design/vsra_pkg.sv]
// ----------------------------------------------------------------------------
// vsra_pkg
// Shared types and constants of the variable-size ring allocator.
// ----------------------------------------------------------------------------
package vsra_pkg;

    localparam int BUFFER_BYTES_DEF = 65536;

    localparam int CNT_W  = 17;
    localparam int HDR_W  = 14;
    localparam int SIZE_W = 13;
    localparam int LOG2_W = 5;

    localparam logic [LOG2_W-1:0] RING_LOG2_RST = 5'd16;
    localparam logic [LOG2_W-1:0] RING_LOG2_MIN = 5'd4;
    localparam logic [LOG2_W-1:0] RING_LOG2_MAX = 5'd16;

    localparam logic [2:0] CMD_RESERVE = 3'd0;
    localparam logic [2:0] CMD_COMMIT  = 3'd1;
    localparam logic [2:0] CMD_PEEK    = 3'd2;
    localparam logic [2:0] CMD_RELEASE = 3'd3;
    localparam logic [2:0] CMD_CLEAR   = 3'd4;

    localparam logic [HDR_W-1:0] HDR_PAD = 14'h2000;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [15:0] request_size;
        logic [15:0] item_offset;
    } t_cmd_item;

    typedef struct packed {
        logic        ok;
        logic [15:0] payload_offset;
        logic [15:0] item_bytes;
        logic [16:0] fill_bytes;
        logic        empty_res;
        logic        full_res;
    } t_result;

    typedef struct packed {
        logic load;
        logic exec;
        logic wr2;
        logic rd2;
        logic fin;
    } t_ctl_cmd;

    typedef struct packed {
        logic wrap_res;
        logic pad_peek;
    } t_dp_status;

endpackage

[design/vsra_ctrl.sv]
// ----------------------------------------------------------------------------
// vsra_ctrl
// Command sequencer: accept, execute, and an optional second header access.
// ----------------------------------------------------------------------------
module vsra_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  vsra_pkg::t_dp_status  i_status,
    output vsra_pkg::t_ctl_cmd    o_cmd,
    output logic                  o_busy
);
    import vsra_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_WR2  = 2'd2;
    localparam logic [1:0] S_RD2  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    t_ctl_cmd   cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    cmd.load = 1'b1;
                    n_state  = S_EXEC;
                end
            end
            S_EXEC: begin
                cmd.exec = 1'b1;
                if (i_status.wrap_res) begin
                    n_state = S_WR2;
                end else if (i_status.pad_peek) begin
                    n_state = S_RD2;
                end else begin
                    cmd.fin = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_WR2: begin
                cmd.wr2 = 1'b1;
                cmd.fin = 1'b1;
                n_state = S_IDLE;
            end
            S_RD2: begin
                cmd.rd2 = 1'b1;
                cmd.fin = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd  = cmd;
    assign o_busy = (r_state != S_IDLE);

`ifndef SYNTHESIS
    a_exec_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |=> r_state == S_EXEC)
        else $error("exec does not follow accept");
    a_fin_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.fin |=> r_state == S_IDLE)
        else $error("sequencer not idle after finish");
    a_status_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({i_status.wrap_res, i_status.pad_peek}))
        else $error("wrap and pad status together");
    a_wr2_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WR2) |-> $past(i_status.wrap_res))
        else $error("second write without wrap");
`endif

endmodule

[design/vsra_dpath.sv]
// ----------------------------------------------------------------------------
// vsra_dpath
// Head/tail counters, header memory, ring size register and result register.
// ----------------------------------------------------------------------------
module vsra_dpath #(
    parameter int BUFFER_BYTES = vsra_pkg::BUFFER_BYTES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  vsra_pkg::t_ctl_cmd    i_cmd,
    input  vsra_pkg::t_cmd_item   i_item,
    input  logic                  i_cfg_we,
    input  logic [4:0]            i_cfg_data,
    output vsra_pkg::t_dp_status  o_status,
    output logic                  o_done,
    output vsra_pkg::t_result     o_result
);
    import vsra_pkg::*;

    localparam int FLOOR_LOG2 = $clog2(BUFFER_BYTES + 1) - 1;
    localparam int MAX_LOG2   = (FLOOR_LOG2 > 16) ? 16 : FLOOR_LOG2;
    localparam int AW         = MAX_LOG2 - 3;
    localparam int DEPTH      = 1 << AW;
    localparam logic [LOG2_W-1:0] BUILD_LOG2 = LOG2_W'(MAX_LOG2);

    logic [HDR_W-1:0] mem [DEPTH];

    logic [LOG2_W-1:0] r_log2;
    logic [CNT_W-1:0]  r_tail, r_head, n_tail, n_head;
    logic [2:0]        r_cmd;
    logic [15:0]       r_req;
    logic              r_ok, n_ok;
    logic [15:0]       r_poff, n_poff;
    logic [15:0]       r_ibytes, n_ibytes;
    logic [HDR_W-1:0]  r_rd_data;
    logic              r_done;
    t_result           r_res;

    logic [LOG2_W-1:0] eff_log2;
    logic [CNT_W-1:0]  ring, mask;
    logic [CNT_W-1:0]  aligned, used, freeb, wpos, rpos, space, off8;
    logic [CNT_W:0]    entry;
    logic [SIZE_W-1:0] hsize;
    logic [CNT_W-1:0]  step, hpos_in, lpos_in;
    logic [CNT_W-1:0]  fill;

    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic              we;
    logic [AW-1:0]     waddr;
    logic [HDR_W-1:0]  wdata;
    t_dp_status        status;

    always_comb begin
        if (r_log2 < RING_LOG2_MIN) begin
            eff_log2 = RING_LOG2_MIN;
        end else if (r_log2 > RING_LOG2_MAX) begin
            eff_log2 = RING_LOG2_MAX;
        end else begin
            eff_log2 = r_log2;
        end
        if (eff_log2 > BUILD_LOG2) begin
            eff_log2 = BUILD_LOG2;
        end
    end

    assign ring    = CNT_W'(1) << eff_log2;
    assign mask    = ring - CNT_W'(1);
    assign off8    = CNT_W'(8) & mask;
    assign aligned = (CNT_W'(r_req) + CNT_W'(7)) & ~CNT_W'(7);
    assign entry   = (CNT_W+1)'(aligned) + (CNT_W+1)'(8);
    assign hsize   = aligned[15:3];
    assign used    = r_tail - r_head;
    assign freeb   = (used >= ring) ? '0 : (ring - used);
    assign wpos    = r_tail & mask;
    assign rpos    = r_head & mask;
    assign space   = ring - wpos;
    assign step    = CNT_W'(8) + CNT_W'({r_rd_data[SIZE_W-1:0], 3'b000});
    assign hpos_in = (CNT_W'(i_item.item_offset) - CNT_W'(8)) & mask;
    assign lpos_in = r_head & mask;

    always_comb begin
        n_tail   = r_tail;
        n_head   = r_head;
        n_ok     = r_ok;
        n_poff   = r_poff;
        n_ibytes = r_ibytes;
        rd_en    = 1'b0;
        rd_addr  = '0;
        we       = 1'b0;
        waddr    = '0;
        wdata    = '0;
        status   = '0;

        if (i_cmd.load) begin
            n_ok     = 1'b0;
            n_poff   = '0;
            n_ibytes = '0;
            rd_en    = 1'b1;
            rd_addr  = (i_item.cmd == CMD_PEEK) ? lpos_in[AW+2:3] : hpos_in[AW+2:3];
        end

        if (i_cmd.exec) begin
            case (r_cmd)
                CMD_RESERVE: begin
                    if (entry <= (CNT_W+1)'(freeb)) begin
                        if ((wpos >= rpos) && ((CNT_W+1)'(space) < entry)) begin
                            if (entry <= (CNT_W+1)'(rpos)) begin
                                we              = 1'b1;
                                waddr           = wpos[AW+2:3];
                                wdata           = HDR_PAD;
                                n_tail          = r_tail + space;
                                n_ok            = 1'b1;
                                n_poff          = off8[15:0];
                                status.wrap_res = 1'b1;
                            end
                        end else begin
                            we     = 1'b1;
                            waddr  = wpos[AW+2:3];
                            wdata  = {1'b0, hsize};
                            n_ok   = 1'b1;
                            n_poff = 16'((wpos + CNT_W'(8)) & mask);
                        end
                    end
                end
                CMD_COMMIT: begin
                    n_ok   = 1'b1;
                    n_tail = r_tail + step;
                end
                CMD_RELEASE: begin
                    n_ok   = 1'b1;
                    n_head = r_head + step;
                end
                CMD_PEEK: begin
                    if (r_head != r_tail) begin
                        if (r_rd_data[HDR_W-1]) begin
                            n_head          = r_head + (ring - rpos);
                            rd_en           = 1'b1;
                            rd_addr         = '0;
                            status.pad_peek = 1'b1;
                        end else begin
                            n_ok     = 1'b1;
                            n_poff   = 16'((rpos + CNT_W'(8)) & mask);
                            n_ibytes = {r_rd_data[SIZE_W-1:0], 3'b000};
                        end
                    end
                end
                CMD_CLEAR: begin
                    n_ok   = 1'b1;
                    n_head = '0;
                    n_tail = '0;
                end
                default: begin
                    n_ok = 1'b0;
                end
            endcase
        end

        if (i_cmd.rd2) begin
            if (r_head != r_tail) begin
                n_ok     = 1'b1;
                n_poff   = off8[15:0];
                n_ibytes = {r_rd_data[SIZE_W-1:0], 3'b000};
            end
        end

        if (i_cmd.wr2) begin
            we    = 1'b1;
            waddr = '0;
            wdata = {1'b0, hsize};
        end
    end

    assign fill = n_tail - n_head;

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_log2 <= RING_LOG2_RST;
            r_tail <= '0;
            r_head <= '0;
            r_done <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_log2 <= i_cfg_data;
            end
            r_tail <= n_tail;
            r_head <= n_head;
            r_done <= i_cmd.fin;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ok     <= n_ok;
        r_poff   <= n_poff;
        r_ibytes <= n_ibytes;
        if (i_cmd.load) begin
            r_cmd <= i_item.cmd;
            r_req <= i_item.request_size;
        end
        if (i_cmd.fin) begin
            r_res.ok             <= n_ok;
            r_res.payload_offset <= n_poff;
            r_res.item_bytes     <= n_ibytes;
            r_res.fill_bytes     <= fill;
            r_res.empty_res      <= (n_head == n_tail);
            r_res.full_res       <= (fill >= ring);
        end
    end

    assign o_status = status;
    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

[design/variable_size_ring_allocator.sv]
// ----------------------------------------------------------------------------
// variable_size_ring_allocator
// Offset allocator for variable-size messages in a power-of-two byte ring.
//
//   channel  direction  handshake                   payload
//   cmd      in         i_start / o_busy            i_item (t_cmd_item)
//   result   out        o_done, one-cycle strobe    o_result (t_result)
//   cfg      in         i_cfg_valid / o_cfg_ready   i_cfg_data (ring_size_log2)
//
// An item is accepted (header read issued), then executed; o_done rises in the
// cycle after the finishing step, while the next item may already be accepted.
// Reserve with a wrap pad and peek over a pad add a second header access:
// one header memory port, one write or read per cycle.
// Reset is synchronous, active low; the header memory is not cleared.
// Results cannot be stalled; cfg is taken only while idle with no item offered.
// ----------------------------------------------------------------------------
module variable_size_ring_allocator #(
    parameter int BUFFER_BYTES = vsra_pkg::BUFFER_BYTES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  vsra_pkg::t_cmd_item  i_item,
    output logic                 o_busy,
    output logic                 o_done,
    output vsra_pkg::t_result    o_result,
    input  logic                 i_cfg_valid,
    input  logic [4:0]           i_cfg_data,
    output logic                 o_cfg_ready
);
    import vsra_pkg::*;

    t_ctl_cmd   ctl_cmd;
    t_dp_status dp_status;
    logic       busy;
    logic       cfg_ready;

    vsra_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_status (dp_status),
        .o_cmd    (ctl_cmd),
        .o_busy   (busy)
    );

    vsra_dpath #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (ctl_cmd),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_valid & cfg_ready),
        .i_cfg_data (i_cfg_data),
        .o_status   (dp_status),
        .o_done     (o_done),
        .o_result   (o_result)
    );

    assign cfg_ready   = ~busy & ~i_start;
    assign o_busy      = busy;
    assign o_cfg_ready = cfg_ready;

endmodule
